/* hw/rtl/rc_channel_frame_builder_core_defines.svh */
// Assertion macros used by the top-level core module.
`ifndef RC_CHANNEL_FRAME_BUILDER_CORE_DEFINES_SVH
`define RC_CHANNEL_FRAME_BUILDER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RCFB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RCFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/rcfb_pkg.sv */
`default_nettype none
package rcfb_pkg;

  localparam int CHANNEL_COUNT = 16;
  localparam int CH_W          = 11;
  localparam int CH_IDX_W      = 4;
  localparam int ACC_W         = CH_W + 7;

  localparam logic [CH_W-1:0] CH_RESET        = 11'd992;
  localparam logic [CH_W-1:0] CLAMP_MIN_RESET = 11'd172;
  localparam logic [CH_W-1:0] CLAMP_MAX_RESET = 11'd1811;

  localparam logic [7:0] SYNC_BYTE  = 8'hC8;
  localparam logic [7:0] FRAME_LEN  = 8'd24;
  localparam logic [7:0] FRAME_TYPE = 8'h16;
  localparam logic [7:0] CRC_POLY   = 8'hD5;

  // Byte positions inside the frame.
  localparam logic [4:0] POS_SYNC = 5'd0;
  localparam logic [4:0] POS_LEN  = 5'd1;
  localparam logic [4:0] POS_TYPE = 5'd2;
  localparam logic [4:0] POS_CRC  = 5'd25;

  typedef enum logic [1:0] {
    OP_CLAMP_WR = 2'd0,
    OP_RAW_WR   = 2'd1,
    OP_FRAME    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_ENABLE    = 2'd0,
    CFG_CLAMP_MIN = 2'd1,
    CFG_CLAMP_MAX = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    FR_IDLE = 1'b0,
    FR_EMIT = 1'b1
  } fr_state_t;

  typedef struct packed {
    logic                en;
    logic                clamp;
    logic [CH_IDX_W-1:0] idx;
    logic [15:0]         value;
  } ch_wr_t;

  typedef struct packed {
    logic       busy;
    logic [4:0] pos;
  } fr_status_t;

  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/rc_channel_frame_builder_core.sv */
// RC channel frame builder.
// Input channel (in_valid / in_stall) carries one command per transfer:
// a clamped or raw write into one of sixteen 11-bit channels, or a frame
// request. Writes produce nothing on the output; an index of 16 or more is
// dropped. A frame request with enable set starts the byte sequencer, which
// emits 26 bytes (sync, length, type, 22 packed payload bytes, CRC-8) one per
// cycle on the output channel (out_valid / out_stall), out_last marking the
// CRC byte. The request is registered into the sequencer state, then each byte
// into the output register; in_stall stays high while the sequencer runs. One
// byte-wide packer/CRC unit handles every payload byte in turn, so throughput
// is one byte per cycle while the output is not stalled.
// A stall on the output holds the current byte and freezes the sequencer.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) are to be made only while idle; the block does not enforce it.
// Synchronous reset sets every channel to 992, enable to 1, the clamp
// bounds to 172 and 1811, and empties the output register.
`default_nettype none
`include "rc_channel_frame_builder_core_defines.svh"
module rc_channel_frame_builder_core
  import rcfb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic [4:0]  in_channel_index,
  input  wire logic [15:0] in_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_tx_byte,
  output logic             out_last
);

  logic            enable_r;
  logic [CH_W-1:0] clamp_min_r;
  logic [CH_W-1:0] clamp_max_r;

  logic              in_acc;
  logic              start;
  ch_wr_t            ch_wr;
  fr_status_t        fr_status;
  logic [CH_IDX_W-1:0] rd_idx;
  logic [CH_W-1:0]   rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b1;
      clamp_min_r <= CLAMP_MIN_RESET;
      clamp_max_r <= CLAMP_MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ENABLE:    enable_r    <= cfg_wdata[0];
        CFG_CLAMP_MIN: clamp_min_r <= cfg_wdata;
        CFG_CLAMP_MAX: clamp_max_r <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  assign in_stall = fr_status.busy;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    ch_wr.en    = 1'b0;
    ch_wr.clamp = 1'b0;
    ch_wr.idx   = in_channel_index[CH_IDX_W-1:0];
    ch_wr.value = in_value;
    start       = 1'b0;
    case (op_t'(in_op))
      OP_CLAMP_WR: begin
        ch_wr.en    = in_acc && !in_channel_index[4];
        ch_wr.clamp = 1'b1;
      end
      OP_RAW_WR: begin
        ch_wr.en = in_acc && !in_channel_index[4];
      end
      OP_FRAME: begin
        start = in_acc && enable_r;
      end
      default: ;
    endcase
  end

  rcfb_chan_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (ch_wr),
    .clamp_min (clamp_min_r),
    .clamp_max (clamp_max_r),
    .rd_idx    (rd_idx),
    .rd_data   (rd_data)
  );

  rcfb_framer u_framer (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .rd_data     (rd_data),
    .rd_idx      (rd_idx),
    .status      (fr_status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_tx_byte (out_tx_byte),
    .out_last    (out_last)
  );

  `RCFB_ASSERT_NEXT(a_start_busy, clk, rst_n, start, in_stall && fr_status.pos == POS_SYNC, "frame request did not start the sequencer")
  `RCFB_ASSERT_NOW(a_end_on_crc, clk, rst_n, $fell(fr_status.busy), out_valid && out_last, "sequencer stopped without loading the CRC byte")

endmodule
`default_nettype wire

/* hw/rtl/rcfb_chan_store.sv */
`default_nettype none
module rcfb_chan_store
  import rcfb_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ch_wr_t              wr,
  input  wire logic [CH_W-1:0]     clamp_min,
  input  wire logic [CH_W-1:0]     clamp_max,
  input  wire logic [CH_IDX_W-1:0] rd_idx,
  output logic [CH_W-1:0]          rd_data
);

  logic [CH_W-1:0] store_r [CHANNEL_COUNT];
  logic [15:0]     lo_v;
  logic [15:0]     hi_v;
  logic [CH_W-1:0] wr_data;

  // Raise to the lower bound first, then limit to the upper bound.
  always_comb begin
    lo_v = (wr.value < {5'd0, clamp_min}) ? {5'd0, clamp_min} : wr.value;
    hi_v = (lo_v > {5'd0, clamp_max}) ? {5'd0, clamp_max} : lo_v;
    wr_data = wr.clamp ? hi_v[CH_W-1:0] : wr.value[CH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        store_r[i] <= CH_RESET;
      end
    end else if (wr.en) begin
      store_r[wr.idx] <= wr_data;
    end
  end

  assign rd_data = store_r[rd_idx];

endmodule
`default_nettype wire

/* hw/rtl/rcfb_framer.sv */
`default_nettype none
module rcfb_framer
  import rcfb_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [CH_W-1:0]     rd_data,
  output logic [CH_IDX_W-1:0]      rd_idx,
  output fr_status_t               status,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               out_tx_byte,
  output logic                     out_last
);

  fr_state_t        state_r, state_nxt;
  logic [4:0]       pos_r, pos_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [4:0]       nbits_r, nbits_nxt;
  logic [4:0]       ch_r, ch_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;

  logic             adv;
  logic [ACC_W-1:0] acc_ext;
  logic [4:0]       nbits_ext;
  logic [7:0]       byte_v;

  assign rd_idx = ch_r[CH_IDX_W-1:0];
  assign adv    = (state_r == FR_EMIT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    acc_nxt       = acc_r;
    nbits_nxt     = nbits_r;
    ch_nxt        = ch_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    acc_ext       = acc_r;
    nbits_ext     = nbits_r;
    byte_v        = 8'd0;

    case (state_r)
      FR_IDLE: begin
        if (start) begin
          state_nxt = FR_EMIT;
          pos_nxt   = POS_SYNC;
          acc_nxt   = '0;
          nbits_nxt = '0;
          ch_nxt    = '0;
          crc_nxt   = '0;
        end
      end
      FR_EMIT: begin
        if (adv) begin
          if (pos_r == POS_SYNC) begin
            byte_v = SYNC_BYTE;
          end else if (pos_r == POS_LEN) begin
            byte_v = FRAME_LEN;
          end else if (pos_r == POS_TYPE) begin
            byte_v  = FRAME_TYPE;
            crc_nxt = crc_step(crc_r, FRAME_TYPE);
          end else if (pos_r == POS_CRC) begin
            byte_v = crc_r;
          end else begin
            // Pull in the next channel when fewer than eight bits are queued and channels remain.
            if (nbits_r < 5'd8 && !ch_r[4]) begin
              acc_ext   = acc_r | ({7'd0, rd_data} << nbits_r[2:0]);
              nbits_ext = nbits_r + 5'd11;
              ch_nxt    = ch_r + 5'd1;
            end
            byte_v    = acc_ext[7:0];
            acc_nxt   = acc_ext >> 8;
            nbits_nxt = nbits_ext - 5'd8;
            crc_nxt   = crc_step(crc_r, acc_ext[7:0]);
          end
          out_valid_nxt = 1'b1;
          out_byte_nxt  = byte_v;
          out_last_nxt  = (pos_r == POS_CRC);
          pos_nxt       = pos_r + 5'd1;
          if (pos_r == POS_CRC) begin
            state_nxt = FR_IDLE;
          end
        end
      end
      default: begin
        state_nxt = FR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FR_IDLE;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    nbits_r    <= nbits_nxt;
    ch_r       <= ch_nxt;
    crc_r      <= crc_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign status.busy = (state_r == FR_EMIT);
  assign status.pos  = pos_r;
  assign out_valid   = out_valid_r;
  assign out_tx_byte = out_byte_r;
  assign out_last    = out_last_r;

endmodule
`default_nettype wire

/* sim/tb_rc_channel_frame_builder_core.sv */
module tb_rc_channel_frame_builder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rcfb_pkg::*;

  localparam logic [1:0] OP_UNDEF      = 2'd3;
  localparam logic [1:0] CFG_UNUSED    = 2'd3;
  localparam int         PAYLOAD_BYTES = 22;
  localparam int         DRAIN_CYCLES  = 8;
  localparam int         END_WAIT      = 1000;
  localparam int         LONG_HOLD     = 300;

  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  idx;
    logic [15:0] value;
  } command_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
  } frame_byte_t;

  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        cfg_we           = 1'b0;
  logic [1:0]  cfg_index        = '0;
  logic [10:0] cfg_wdata        = '0;
  logic        in_valid         = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op            = '0;
  logic [4:0]  in_channel_index = '0;
  logic [15:0] in_value         = '0;
  logic        out_valid;
  logic        out_stall        = 1'b0;
  logic [7:0]  out_tx_byte;
  logic        out_last;

  // Shadow copy of the block's channels and registers.
  logic [CH_W-1:0] shadow_ch [CHANNEL_COUNT];
  logic            shadow_enable;
  logic [CH_W-1:0] shadow_lo;
  logic [CH_W-1:0] shadow_hi;

  command_t    pending_cmds[$];
  frame_byte_t expected_bytes[$];

  bit idle_on   = 1'b1;
  bit hold_arm  = 1'b0;
  bit hold_done = 1'b0;
  int gap_left  = 0;
  int stall_left = 0;
  int hold_left = 0;
  int errors    = 0;

  rc_channel_frame_builder_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_channel_index (in_channel_index),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tx_byte      (out_tx_byte),
    .out_last         (out_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] crc8_add(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    logic       fb;
    int         i;
    r = crc;
    for (i = 7; i >= 0; i--) begin
      fb = r[7] ^ data[i];
      r = {r[6:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  // Update the shadow channels and queue the frame bytes this command produces.
  function automatic void apply_command(input command_t c);
    logic [15:0]                 v;
    logic [CHANNEL_COUNT*CH_W-1:0] packed_ch;
    logic [7:0]                  crc;
    logic [7:0]                  b;
    int                          i;
    if (c.op == OP_CLAMP_WR || c.op == OP_RAW_WR) begin
      if (c.idx < CHANNEL_COUNT) begin
        v = c.value;
        if (c.op == OP_CLAMP_WR) begin
          if (v < {5'd0, shadow_lo}) v = {5'd0, shadow_lo};
          if (v > {5'd0, shadow_hi}) v = {5'd0, shadow_hi};
        end
        shadow_ch[c.idx[3:0]] = v[CH_W-1:0];
      end
    end else if (c.op == OP_FRAME && shadow_enable) begin
      for (i = 0; i < CHANNEL_COUNT; i++) begin
        packed_ch[i*CH_W +: CH_W] = shadow_ch[i];
      end
      expected_bytes.push_back('{SYNC_BYTE, 1'b0});
      expected_bytes.push_back('{FRAME_LEN, 1'b0});
      expected_bytes.push_back('{FRAME_TYPE, 1'b0});
      crc = crc8_add(8'h00, FRAME_TYPE);
      for (i = 0; i < PAYLOAD_BYTES; i++) begin
        b = packed_ch[i*8 +: 8];
        crc = crc8_add(crc, b);
        expected_bytes.push_back('{b, 1'b0});
      end
      expected_bytes.push_back('{crc, 1'b1});
    end
  endfunction

  // Input driver: hold a stalled transfer, otherwise idle or present the next command.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_command(command_t'{in_op, in_channel_index, in_value});
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
          gap_left <= $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          in_valid         <= 1'b1;
          in_op            <= pending_cmds[0].op;
          in_channel_index <= pending_cmds[0].idx;
          in_value         <= pending_cmds[0].value;
          void'(pending_cmds.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check each byte transfer, drive stall bursts and the long hold-off.
  always @(posedge clk) begin
    frame_byte_t e;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected byte: tx_byte 0x%02h, last %0b", out_tx_byte, out_last);
          errors++;
        end else begin
          e = expected_bytes.pop_front();
          if (out_tx_byte !== e.tx_byte) begin
            $error("tx_byte mismatch: expected 0x%02h, actual 0x%02h", e.tx_byte, out_tx_byte);
            errors++;
          end
          if (out_last !== e.last) begin
            $error("last mismatch: expected %0b, actual %0b", e.last, out_last);
            errors++;
          end
        end
      end
      if (hold_arm && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left <= $urandom_range(0, 9);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_cmd(input logic [1:0] op, input logic [4:0] idx, input logic [15:0] value);
    pending_cmds.push_back('{op, idx, value});
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ENABLE:    shadow_enable = data[0];
      CFG_CLAMP_MIN: shadow_lo = data;
      CFG_CLAMP_MAX: shadow_hi = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Wait until every command is taken and every frame byte is out, then let writes settle.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_bytes.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Queue random commands until the given number of effective ones, then drain.
  task automatic run_random(input int count, input bit with_idle);
    command_t    c;
    logic [15:0] delta;
    int          n;
    idle_on = with_idle;
    n = 0;
    while (n < count) begin
      c.op = $urandom_range(0, 99) < 40 ? OP_CLAMP_WR : OP_RAW_WR;
      case ($urandom_range(0, 9))
        0, 1, 2: c.op = OP_FRAME;
        3:       if ($urandom_range(0, 2) == 0) c.op = OP_UNDEF;
        default: ;
      endcase
      c.idx = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(16, 31))
                                          : 5'($urandom_range(0, 15));
      delta = 16'($urandom_range(0, 2));
      case ($urandom_range(0, 3))
        0:       c.value = 16'($urandom);
        1:       c.value = 16'($urandom_range(0, 2047));
        2:       c.value = {5'd0, shadow_lo} + delta - 16'd1;
        default: c.value = {5'd0, shadow_hi} + delta - 16'd1;
      endcase
      pending_cmds.push_back(c);
      // Dropped writes, undefined ops and disabled frame requests do not count.
      if (!(c.op == OP_UNDEF || (c.op == OP_FRAME ? !shadow_enable : c.idx >= CHANNEL_COUNT)))
        n++;
    end
    wait_drained();
  endtask

  initial begin
    int i;
    int waited;
    for (i = 0; i < CHANNEL_COUNT; i++) begin
      shadow_ch[i] = CH_RESET;
    end
    shadow_enable = 1'b1;
    shadow_lo     = CLAMP_MIN_RESET;
    shadow_hi     = CLAMP_MAX_RESET;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset values, clamp edges, truncation, dropped indexes, undefined op.
    push_cmd(OP_FRAME,    5'd0,  16'h0000);
    push_cmd(OP_CLAMP_WR, 5'd0,  16'h0000);
    push_cmd(OP_CLAMP_WR, 5'd15, 16'hFFFF);
    push_cmd(OP_CLAMP_WR, 5'd6,  16'd171);
    push_cmd(OP_CLAMP_WR, 5'd7,  16'd172);
    push_cmd(OP_CLAMP_WR, 5'd8,  16'd1811);
    push_cmd(OP_CLAMP_WR, 5'd9,  16'd1812);
    push_cmd(OP_CLAMP_WR, 5'd10, 16'h0805);
    push_cmd(OP_RAW_WR,   5'd2,  16'hFFFF);
    push_cmd(OP_RAW_WR,   5'd3,  16'h0000);
    push_cmd(OP_RAW_WR,   5'd4,  16'hA800);
    push_cmd(OP_RAW_WR,   5'd5,  16'h5555);
    push_cmd(OP_RAW_WR,   5'd11, 16'hF800);
    push_cmd(OP_RAW_WR,   5'd16, 16'h0123);
    push_cmd(OP_CLAMP_WR, 5'd31, 16'h0456);
    push_cmd(OP_UNDEF,    5'd31, 16'hFFFF);
    push_cmd(OP_FRAME,    5'd31, 16'hFFFF);
    wait_drained();

    // Full-range bounds.
    write_reg(CFG_CLAMP_MIN, 11'd0);
    write_reg(CFG_CLAMP_MAX, 11'h7FF);
    push_cmd(OP_CLAMP_WR, 5'd0, 16'hFFFF);
    push_cmd(OP_CLAMP_WR, 5'd1, 16'h0000);
    push_cmd(OP_FRAME,    5'd0, 16'h0000);
    run_random(40, 1'b1);

    // Inverted bounds: every clamped write lands on the upper bound.
    write_reg(CFG_CLAMP_MIN, 11'h7FF);
    write_reg(CFG_CLAMP_MAX, 11'd0);
    push_cmd(OP_CLAMP_WR, 5'd2, 16'h1234);
    push_cmd(OP_FRAME,    5'd0, 16'h0000);
    run_random(20, 1'b1);

    // Disabled: writes still land, frame requests produce nothing.
    write_reg(CFG_ENABLE, 11'h7FE);
    write_reg(CFG_UNUSED, 11'h7FF);
    write_reg(CFG_CLAMP_MIN, 11'd100);
    write_reg(CFG_CLAMP_MAX, 11'd1900);
    run_random(15, 1'b1);

    // Re-enable, then hold the output off long enough to back up the input.
    write_reg(CFG_ENABLE, 11'h001);
    write_reg(CFG_CLAMP_MIN, 11'($urandom_range(0, 1023)));
    write_reg(CFG_CLAMP_MAX, 11'($urandom_range(1024, 2047)));
    hold_arm = 1'b1;
    push_cmd(OP_FRAME, 5'd0, 16'h0000);
    push_cmd(OP_FRAME, 5'd0, 16'h0000);
    push_cmd(OP_FRAME, 5'd0, 16'h0000);
    run_random(45, 1'b1);

    // Back-to-back traffic at reset bounds.
    write_reg(CFG_CLAMP_MIN, CLAMP_MIN_RESET);
    write_reg(CFG_CLAMP_MAX, CLAMP_MAX_RESET);
    idle_on = 1'b0;
    run_random(45, 1'b0);

    waited = 0;
    while (expected_bytes.size() != 0 && waited < END_WAIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_bytes.size() != 0) begin
      $error("frame bytes never transferred: %0d", expected_bytes.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/rcfb_pkg.sv
hw/rtl/rcfb_chan_store.sv
hw/rtl/rcfb_framer.sv
hw/rtl/rc_channel_frame_builder_core.sv
sim/tb_rc_channel_frame_builder_core.sv
